/* sv/pap_pkg.sv */
// shared constants and types for the polygon area and perimeter block
package pap_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int MAX_POINTS_DEF = 1024;

    localparam int CROSS_W  = 51;
    localparam int AREA_W   = 50;
    localparam int LEN_W    = 31;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    localparam int MIN_CORNERS = 3;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_MANY = 2'd2
    } status_t;

endpackage

/* sv/polygon_area_perimeter.sv */
// polygon area and perimeter: one shared multiplier and a bit-pair square root per edge
// a corner word that opens an edge holds s_ready low while the edge is worked: four products
// through the multiplier, the squared-length add, one square-root step per cycle, then the
// accumulate; an error finish goes straight to the result state, a valid finish first runs
// the closing edge the same way, and the result waits there until the output register is free;
// aresetn is synchronous and active low; it clears the sums, the count and the sequencer
module polygon_area_perimeter #(
    parameter int COORD_BITS = pap_pkg::COORD_BITS_DEF,
    parameter int MAX_POINTS = pap_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic signed [COORD_BITS-1:0]        s_x,
    input  logic signed [COORD_BITS-1:0]        s_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pap_pkg::STATUS_W-1:0]        m_status,
    output logic [pap_pkg::AREA_W-1:0]          m_area,
    output logic [pap_pkg::LEN_W-1:0]           m_perimeter,
    output logic [pap_pkg::TOTAL_W-1:0]         m_point_total
);

    localparam int CB    = COORD_BITS;
    localparam int PW    = 2 * CB + 2;
    localparam int SQW   = (PW > 64) ? 64 : PW;
    localparam int ITERS = SQW / 2;
    localparam int IW    = $clog2(ITERS);
    localparam int EW    = (PW > pap_pkg::CROSS_W) ? PW : pap_pkg::CROSS_W;
    localparam int LSW   = ((SQW > pap_pkg::LEN_W) ? SQW : pap_pkg::LEN_W) + 1;
    localparam int CNTW  = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_M1   = 9'b000000010,
        S_M2   = 9'b000000100,
        S_M3   = 9'b000001000,
        S_M4   = 9'b000010000,
        S_SQ0  = 9'b000100000,
        S_SQRT = 9'b001000000,
        S_ACC  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CB-1:0]            first_x_reg, first_x_next;
    logic signed [CB-1:0]            first_y_reg, first_y_next;
    logic signed [CB-1:0]            prev_x_reg, prev_x_next;
    logic signed [CB-1:0]            prev_y_reg, prev_y_next;
    logic signed [CB-1:0]            cur_x_reg, cur_x_next;
    logic signed [CB-1:0]            cur_y_reg, cur_y_next;
    logic [CNTW-1:0]                 count_reg, count_next;
    logic [pap_pkg::CROSS_W-1:0]     cross_reg, cross_next;
    logic [pap_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            ovf_reg, ovf_next;
    logic                            closing_reg, closing_next;
    pap_pkg::status_t                status_reg, status_next;

    logic signed [PW-1:0]            prod_reg, prod_next;
    logic [SQW-1:0]                  sq_reg, sq_next;
    logic [SQW-1:0]                  root_reg, root_next;
    logic [SQW-1:0]                  bit_reg, bit_next;
    logic [IW-1:0]                   iter_reg, iter_next;

    logic                            m_valid_reg, m_valid_next;
    pap_pkg::status_t                m_status_reg, m_status_next;
    logic [pap_pkg::AREA_W-1:0]      m_area_reg, m_area_next;
    logic [pap_pkg::LEN_W-1:0]       m_perim_reg, m_perim_next;
    logic [pap_pkg::TOTAL_W-1:0]     m_total_reg, m_total_next;

    // the shared multiplier
    logic signed [CB:0]              mul_a, mul_b;
    logic signed [PW-1:0]            mul_p;
    logic signed [CB:0]              dx, dy;
    logic signed [EW-1:0]            prod_ext;
    logic [SQW-1:0]                  root_plus;
    logic [LSW-1:0]                  len_sum;
    logic [pap_pkg::CROSS_W-1:0]     cross_neg;
    logic [pap_pkg::AREA_W-1:0]      area_abs;

    assign mul_p     = mul_a * mul_b;
    assign dx        = (CB + 1)'(cur_x_reg) - (CB + 1)'(prev_x_reg);
    assign dy        = (CB + 1)'(cur_y_reg) - (CB + 1)'(prev_y_reg);
    assign prod_ext  = EW'(prod_reg);
    assign root_plus = root_reg + bit_reg;
    assign len_sum   = LSW'(len_reg) + LSW'(root_reg);
    assign cross_neg = -cross_reg;

    // magnitude of the doubled-area sum, saturating when the negation reaches the top bit
    always_comb begin
        if (!cross_reg[pap_pkg::CROSS_W-1]) begin
            area_abs = cross_reg[pap_pkg::AREA_W-1:0];
        end else if (cross_neg[pap_pkg::CROSS_W-1]) begin
            area_abs = {pap_pkg::AREA_W{1'b1}};
        end else begin
            area_abs = cross_neg[pap_pkg::AREA_W-1:0];
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        count_next    = count_reg;
        cross_next    = cross_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        closing_next  = closing_reg;
        status_next   = status_reg;
        prod_next     = prod_reg;
        sq_next       = sq_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        iter_next     = iter_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_area_next   = m_area_reg;
        m_perim_next  = m_perim_reg;
        m_total_next  = m_total_reg;
        mul_a         = '0;
        mul_b         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == pap_pkg::KIND_POINT) begin
                        if (count_reg == '0) begin
                            first_x_next = s_x;
                            first_y_next = s_y;
                            prev_x_next  = s_x;
                            prev_y_next  = s_y;
                            count_next   = CNTW'(1);
                        end else if (count_reg < CNTW'(MAX_POINTS)) begin
                            cur_x_next   = s_x;
                            cur_y_next   = s_y;
                            closing_next = 1'b0;
                            state_next   = S_M1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        if (ovf_reg) begin
                            status_next = pap_pkg::STATUS_MANY;
                            state_next  = S_DONE;
                        end else if (count_reg < CNTW'(pap_pkg::MIN_CORNERS)) begin
                            status_next = pap_pkg::STATUS_FEW;
                            state_next  = S_DONE;
                        end else begin
                            // closing edge runs from the last corner back to the first
                            cur_x_next   = first_x_reg;
                            cur_y_next   = first_y_reg;
                            closing_next = 1'b1;
                            state_next   = S_M1;
                        end
                    end
                end
            end
            S_M1: begin
                mul_a      = (CB + 1)'(prev_x_reg);
                mul_b      = (CB + 1)'(cur_y_reg);
                prod_next  = mul_p;
                state_next = S_M2;
            end
            S_M2: begin
                mul_a      = (CB + 1)'(cur_x_reg);
                mul_b      = (CB + 1)'(prev_y_reg);
                prod_next  = mul_p;
                cross_next = cross_reg + prod_ext[pap_pkg::CROSS_W-1:0];
                state_next = S_M3;
            end
            S_M3: begin
                mul_a      = dx;
                mul_b      = dx;
                prod_next  = mul_p;
                cross_next = cross_reg - prod_ext[pap_pkg::CROSS_W-1:0];
                state_next = S_M4;
            end
            S_M4: begin
                mul_a      = dy;
                mul_b      = dy;
                prod_next  = mul_p;
                sq_next    = prod_reg[SQW-1:0];
                state_next = S_SQ0;
            end
            S_SQ0: begin
                sq_next    = sq_reg + prod_reg[SQW-1:0];
                root_next  = '0;
                bit_next   = SQW'(1) << (SQW - 2);
                iter_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (sq_reg >= root_plus) begin
                    sq_next   = sq_reg - root_plus;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg + IW'(1);
                if (iter_reg == IW'(ITERS - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                if (len_sum > LSW'(pap_pkg::LEN_MAX)) begin
                    len_next = pap_pkg::LEN_MAX;
                end else begin
                    len_next = len_sum[pap_pkg::LEN_W-1:0];
                end
                if (closing_reg) begin
                    status_next = pap_pkg::STATUS_OK;
                    state_next  = S_DONE;
                end else begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    count_next  = count_reg + CNTW'(1);
                    state_next  = S_IDLE;
                end
            end
            S_DONE: begin
                // wait here until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_total_next  = pap_pkg::TOTAL_W'(count_reg);
                    if (status_reg == pap_pkg::STATUS_OK) begin
                        m_area_next  = area_abs;
                        m_perim_next = len_reg;
                    end else begin
                        m_area_next  = '0;
                        m_perim_next = '0;
                    end
                    count_next = '0;
                    cross_next = '0;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            cross_reg   <= '0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            closing_reg <= 1'b0;
            status_reg  <= pap_pkg::STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            count_reg   <= count_next;
            cross_reg   <= cross_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            closing_reg <= closing_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        prod_reg     <= prod_next;
        sq_reg       <= sq_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        iter_reg     <= iter_next;
        m_status_reg <= m_status_next;
        m_area_reg   <= m_area_next;
        m_perim_reg  <= m_perim_next;
        m_total_reg  <= m_total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_area        = m_area_reg;
    assign m_perimeter   = m_perim_reg;
    assign m_point_total = m_total_reg;

    // error results carry no area or perimeter
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != pap_pkg::STATUS_OK)) |-> ((m_area == '0) && (m_perimeter == '0)))
        else $error("error word carries nonzero area or perimeter");

    // the corner count never passes the limit
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_POINTS))
        else $error("corner count beyond limit");

    // overflow only happens with a full point list
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == CNTW'(MAX_POINTS)))
        else $error("overflow flag set before the list is full");

    // a corner that starts an edge keeps the block busy on the next cycle
    a_edge_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == pap_pkg::KIND_POINT) && (count_reg != '0)
            && (count_reg < CNTW'(MAX_POINTS))) |=> !s_ready)
        else $error("edge work skipped");

endmodule

/* bench/pap_checker.sv */
`timescale 1ns / 100ps
// watches both channels of the polygon block, predicts each result and compares it
module pap_checker (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    input  logic                                      s_ready,
    input  logic                                      s_kind,
    input  logic signed [pap_pkg::COORD_BITS_DEF-1:0] s_x,
    input  logic signed [pap_pkg::COORD_BITS_DEF-1:0] s_y,
    input  logic                                      m_valid,
    input  logic                                      m_ready,
    input  logic [pap_pkg::STATUS_W-1:0]              m_status,
    input  logic [pap_pkg::AREA_W-1:0]                m_area,
    input  logic [pap_pkg::LEN_W-1:0]                 m_perimeter,
    input  logic [pap_pkg::TOTAL_W-1:0]               m_point_total,
    output int                                        fail_count,
    output int                                        results_owed
);

    typedef struct packed {
        pap_pkg::status_t                  status;
        logic [pap_pkg::AREA_W-1:0]        area;
        logic [pap_pkg::LEN_W-1:0]         perimeter;
        logic [pap_pkg::TOTAL_W-1:0]       total;
    } shape_result_t;

    // shadow of the block's running state
    logic signed [pap_pkg::COORD_BITS_DEF-1:0] anchor_x, anchor_y, tail_x, tail_y;
    logic [pap_pkg::TOTAL_W-1:0]               corners;
    logic [pap_pkg::CROSS_W-1:0]               shoelace_acc;
    logic [pap_pkg::LEN_W-1:0]                 perim_acc;
    logic                                      too_many;

    shape_result_t owed_q[$];
    shape_result_t due;
    shape_result_t got;
    logic [pap_pkg::CROSS_W-1:0] size_mag;

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    task automatic add_side(input longint ax, input longint ay, input longint bx,
                            input longint by);
        longint dx;
        longint dy;
        longint unsigned len;
        dx = bx - ax;
        dy = by - ay;
        len = root_floor(longint'(dx * dx + dy * dy));
        shoelace_acc = shoelace_acc + pap_pkg::CROSS_W'(ax * by - bx * ay);
        if (perim_acc + len > pap_pkg::LEN_MAX)
            perim_acc = pap_pkg::LEN_MAX;
        else
            perim_acc = perim_acc + pap_pkg::LEN_W'(len);
    endtask

    task automatic clear_shape();
        anchor_x = '0;
        anchor_y = '0;
        tail_x = '0;
        tail_y = '0;
        corners = '0;
        shoelace_acc = '0;
        perim_acc = '0;
        too_many = 1'b0;
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_shape();
            owed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{pap_pkg::status_t'(m_status), m_area, m_perimeter, m_point_total};
                if (owed_q.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    due = owed_q.pop_front();
                    if (got.status != due.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                got.status, due.status));
                    if (got.area != due.area)
                        flag_mismatch($sformatf("area %0h, expected %0h",
                                                got.area, due.area));
                    if (got.perimeter != due.perimeter)
                        flag_mismatch($sformatf("perimeter %0h, expected %0h",
                                                got.perimeter, due.perimeter));
                    if (got.total != due.total)
                        flag_mismatch($sformatf("point total %0d, expected %0d",
                                                got.total, due.total));
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == pap_pkg::KIND_FINISH) begin
                    due.total = corners;
                    due.area = '0;
                    due.perimeter = '0;
                    if (too_many) begin
                        due.status = pap_pkg::STATUS_MANY;
                    end else if (corners < pap_pkg::MIN_CORNERS) begin
                        due.status = pap_pkg::STATUS_FEW;
                    end else begin
                        // closing side back to the first corner
                        add_side(tail_x, tail_y, anchor_x, anchor_y);
                        size_mag = shoelace_acc[pap_pkg::CROSS_W-1] ? -shoelace_acc
                                                                    : shoelace_acc;
                        due.area = size_mag[pap_pkg::CROSS_W-1] ? '1
                                                                : size_mag[pap_pkg::AREA_W-1:0];
                        due.perimeter = perim_acc;
                        due.status = pap_pkg::STATUS_OK;
                    end
                    owed_q.insert(owed_q.size(), due);
                    clear_shape();
                end else if (corners == 0) begin
                    anchor_x = s_x;
                    anchor_y = s_y;
                    tail_x = s_x;
                    tail_y = s_y;
                    corners = pap_pkg::TOTAL_W'(1);
                end else if (corners < pap_pkg::MAX_POINTS_DEF) begin
                    add_side(tail_x, tail_y, s_x, s_y);
                    tail_x = s_x;
                    tail_y = s_y;
                    corners = corners + 1'b1;
                end else begin
                    too_many = 1'b1;
                end
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// top of the polygon area and perimeter bench: clock, reset, stimulus and verdict
module tb;

    localparam int CW          = pap_pkg::COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 30;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t COORD_LO = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t COORD_HI = {1'b0, {(CW-1){1'b1}}};

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_kind = pap_pkg::KIND_POINT;
    coord_t                             s_x = '0;
    coord_t                             s_y = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [pap_pkg::STATUS_W-1:0]       m_status;
    logic [pap_pkg::AREA_W-1:0]         m_area;
    logic [pap_pkg::LEN_W-1:0]          m_perimeter;
    logic [pap_pkg::TOTAL_W-1:0]        m_point_total;

    int fail_count;
    int results_owed;
    int words_sent = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int cycle_n = 0;

    polygon_area_perimeter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_x           (s_x),
        .s_y           (s_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_area        (m_area),
        .m_perimeter   (m_perimeter),
        .m_point_total (m_point_total)
    );

    pap_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_x           (s_x),
        .s_y           (s_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_area        (m_area),
        .m_perimeter   (m_perimeter),
        .m_point_total (m_point_total),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_n);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic coord_t pick_coord(input bit wide);
        if (wide)
            return CW'($urandom);
        return CW'($urandom_range(4095) - 2048);
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic offer_word(input logic kind, input coord_t px, input coord_t py);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_x <= px;
        s_y <= py;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic send_polygon(input int n, input bit wide);
        for (int i = 0; i < n; i++)
            offer_word(pap_pkg::KIND_POINT, pick_coord(wide), pick_coord(wide));
        offer_word(pap_pkg::KIND_FINISH, pick_coord(1'b1), pick_coord(1'b1));
    endtask

    initial begin
        int target;
        int pick;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty finish, coordinates on it must be ignored
        offer_word(pap_pkg::KIND_FINISH, COORD_LO, COORD_HI);
        // one and two corners are too few
        offer_word(pap_pkg::KIND_POINT, COORD_LO, COORD_LO);
        offer_word(pap_pkg::KIND_FINISH, COORD_HI, COORD_LO);
        offer_word(pap_pkg::KIND_POINT, COORD_HI, COORD_HI);
        offer_word(pap_pkg::KIND_POINT, COORD_LO, COORD_HI);
        offer_word(pap_pkg::KIND_FINISH, '0, '0);
        // widest triangle
        offer_word(pap_pkg::KIND_POINT, COORD_LO, COORD_LO);
        offer_word(pap_pkg::KIND_POINT, COORD_HI, COORD_LO);
        offer_word(pap_pkg::KIND_POINT, COORD_LO, COORD_HI);
        offer_word(pap_pkg::KIND_FINISH, COORD_HI, COORD_HI);
        // clockwise square of side 256 gives a negative sum
        offer_word(pap_pkg::KIND_POINT, 20'sd0, 20'sd0);
        offer_word(pap_pkg::KIND_POINT, 20'sd0, 20'sd256);
        offer_word(pap_pkg::KIND_POINT, 20'sd256, 20'sd256);
        offer_word(pap_pkg::KIND_POINT, 20'sd256, 20'sd0);
        offer_word(pap_pkg::KIND_FINISH, '0, '0);
        // collinear corners, zero area
        offer_word(pap_pkg::KIND_POINT, 20'sd0, 20'sd0);
        offer_word(pap_pkg::KIND_POINT, 20'sd100, 20'sd100);
        offer_word(pap_pkg::KIND_POINT, 20'sd200, 20'sd200);
        offer_word(pap_pkg::KIND_FINISH, '0, '0);
        // repeated corner, zero-length sides
        offer_word(pap_pkg::KIND_POINT, -20'sd5, 20'sd5);
        offer_word(pap_pkg::KIND_POINT, -20'sd5, 20'sd5);
        offer_word(pap_pkg::KIND_POINT, -20'sd5, 20'sd5);
        offer_word(pap_pkg::KIND_FINISH, '0, '0);

        // fill the corner list up to the limit, then one corner past it
        send_polygon(pap_pkg::MAX_POINTS_DEF + 1, 1'b1);

        // receiver holds off while triangles keep coming so the block backs up
        hold_asks++;
        repeat (6) send_polygon(3, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 81;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 81;
                end
                default: begin
                    send_idle = 37;
                    recv_stall = 37;
                end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_polygon($urandom_range(12, 3), 1'($urandom_range(1)));
                else if (pick < 85)
                    send_polygon($urandom_range(2), 1'($urandom_range(1)));
                else
                    offer_word(1'($urandom_range(1)), pick_coord(1'b1), pick_coord(1'b1));
            end
        end
        s_valid <= 1'b0;

        while (results_owed != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/pap_pkg.sv
sv/polygon_area_perimeter.sv
bench/pap_checker.sv
bench/tb.sv
